// ===== hw/rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg: shared constants for the sliding window mean
// Widths of samples, window size, ring address and running total.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW = 4096;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int WIN_W      = ADDR_W + 1;
    localparam int SAMPLE_W   = 16;
    // magnitude of a full window sum: MAX_WINDOW * 2^(SAMPLE_W-1)
    localparam int MAG_W      = ADDR_W + SAMPLE_W;
    localparam int TOTAL_W    = MAG_W + 1;
    localparam int DIV_CNT_W  = $clog2(MAG_W);
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);

endpackage

// ===== hw/rtl/swm_ring.sv =====
// ----------------------------------------------------------------------------
// swm_ring: sample history store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swm_ring
    import swm_pkg::*;
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic signed [SAMPLE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr,
    output logic signed [SAMPLE_W-1:0] rdata
);

    logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/swm_divider.sv =====
// ----------------------------------------------------------------------------
// swm_divider: serial unsigned divider
// Restoring division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module swm_divider
    import swm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MAG_W-1:0]     dividend,
    input  logic [WIN_W-1:0]     divisor,
    output logic                 done,
    output logic [MAG_W-1:0]     quotient
);

    logic [WIN_W-1:0]     rem_reg, rem_next;
    logic [MAG_W-1:0]     quo_reg, quo_next;
    logic [WIN_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WIN_W:0]       rem_shift;
    logic [WIN_W:0]       diff;

    always_comb
    begin
        rem_shift  = {rem_reg, quo_reg[MAG_W-1]};
        diff       = rem_shift - {1'b0, dvs_reg};
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            quo_next   = dividend;
            dvs_next   = divisor;
            count_next = DIV_CNT_W'(MAG_W - 1);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the difference when the shifted remainder covers the divisor
            if (!diff[WIN_W])
            begin
                rem_next = diff[WIN_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[WIN_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            quo_reg   <= '0;
            dvs_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            dvs_reg   <= dvs_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/sliding_window_mean.sv =====
// ----------------------------------------------------------------------------
// sliding_window_mean: moving average over the last window_size samples
// Sequencer around a sample ring and a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on sample_valid/sample_stall with a 16-bit signed
//   sample; each produces one request on average_valid/average_stall holding
//   the mean of the last window_size samples (fewer while the window fills),
//   truncated toward zero. A window size of zero returns 0 and keeps history.
//   Sizes above 4096 act as 4096.
//   window_we/window_wdata write the window size and restart the history;
//   write only while the block is idle.
//   Path from accept to average_valid: the ring read and update state, the
//   divider load state, the bit-serial divider (28 quotient bits, one per
//   cycle, then done), the sign step on done and the hand-off to the output
//   register. A zero window skips the ring and divider and goes straight to
//   the hand-off. One sample is in flight at a time; the output register
//   lets the next sample enter while a result waits, and a stalled receiver
//   holds the block only when a second result is ready.
//   Reset sets the window to 16 and empties the history; the ring contents
//   need no clearing.
// ----------------------------------------------------------------------------
module sliding_window_mean
    import swm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       window_we,
    input  logic [WIN_W-1:0]           window_wdata,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       average_valid,
    input  logic                       average_stall,
    output logic signed [SAMPLE_W-1:0] average
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [WIN_W-1:0]            window_reg, window_next;
    logic [ADDR_W-1:0]           wptr_reg, wptr_next;
    logic [WIN_W-1:0]            fill_reg, fill_next;
    logic signed [TOTAL_W-1:0]   total_reg, total_next;
    logic signed [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                        neg_reg, neg_next;
    logic [SAMPLE_W-1:0]         res_reg, res_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]         average_reg, average_next;

    logic [WIN_W-1:0]            win_eff;
    logic [ADDR_W-1:0]           wptr_cur;
    logic [WIN_W-1:0]            wptr_inc;
    logic                        full;
    logic                        accept;
    logic signed [SAMPLE_W-1:0]  old_sample;
    logic signed [TOTAL_W-1:0]   add_term;
    logic signed [TOTAL_W-1:0]   sub_term;
    logic [TOTAL_W-1:0]          total_abs;
    logic                        div_start;
    logic                        div_done;
    logic [MAG_W-1:0]            div_quotient;

    assign win_eff  = (window_reg > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_reg;
    assign wptr_cur = ({1'b0, wptr_reg} >= win_eff) ? '0 : wptr_reg;
    assign wptr_inc = {1'b0, wptr_reg} + WIN_W'(1);
    assign full     = (fill_reg >= win_eff);
    assign accept   = sample_valid && !sample_stall;
    assign add_term = TOTAL_W'(sample_reg);
    assign sub_term = full ? TOTAL_W'(old_sample) : '0;
    assign total_abs = total_reg[TOTAL_W-1] ? TOTAL_W'(-total_reg) : total_reg;
    assign div_start = (state_reg == ST_START);

    swm_ring u_ring (
        .clk   (clk),
        .we    (state_reg == ST_READ),
        .waddr (wptr_reg),
        .wdata (sample_reg),
        .raddr (wptr_cur),
        .rdata (old_sample)
    );

    swm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_abs[MAG_W-1:0]),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        wptr_next      = wptr_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        sample_next    = sample_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        average_next   = average_reg;

        // drop the result once the receiver takes it
        if (out_valid_reg && !average_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (window_we)
                begin
                    window_next = window_wdata;
                    wptr_next   = '0;
                    fill_next   = '0;
                    total_next  = '0;
                end
                else if (accept)
                begin
                    sample_next = sample;
                    if (win_eff == '0)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        wptr_next  = wptr_cur;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // add the newest sample, retire the oldest once the window is full
                total_next = total_reg + add_term - sub_term;
                if (!full)
                begin
                    fill_next = fill_reg + WIN_W'(1);
                end
                wptr_next  = (wptr_inc >= win_eff) ? '0 : wptr_inc[ADDR_W-1:0];
                state_next = ST_START;
            end
            ST_START:
            begin
                neg_next   = total_reg[TOTAL_W-1];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = neg_reg ? (~div_quotient[SAMPLE_W-1:0] + SAMPLE_W'(1))
                                         : div_quotient[SAMPLE_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !average_stall)
                begin
                    out_valid_next = 1'b1;
                    average_next   = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            wptr_reg      <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            sample_reg    <= '0;
            neg_reg       <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            average_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            sample_reg    <= sample_next;
            neg_reg       <= neg_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            average_reg   <= average_next;
        end
    end

    assign sample_stall  = (state_reg != ST_IDLE);
    assign average_valid = out_valid_reg;
    assign average       = average_reg;

endmodule
